// ----- rtl/sgtd_pkg.sv -----
// Shared types and constants of the speculative-gadget taint detector.
package sgtd_pkg;

    // Window tracking modes, as reported in fsm_state.
    typedef logic [1:0] mode_t;

    localparam mode_t ST_IDLE  = 2'd0;
    localparam mode_t ST_OPEN  = 2'd1;
    localparam mode_t ST_TAINT = 2'd2;
    localparam mode_t ST_FOUND = 2'd3;

    // Fixed field widths of the stream items.
    localparam int PC_FIELD_W   = 48;
    localparam int REG_FIELD_W  = 9;
    localparam int COUNT_W      = 32;
    localparam int UNIQUE_W     = 7;
    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 136;
    localparam int IN_PAD_W     = 6;
    localparam int OUT_PAD_W    = 5;

    // Outcome of one lookup-and-insert pass through a PC set.
    typedef struct packed {
        logic done;
        logic is_new;
        logic full;
    } search_res_t;

endpackage

// ----- rtl/sgtd_pc_cell.sv -----
// One entry of a PC set: stores a PC and passes a search token and hit flag on.
module sgtd_pc_cell #(
    parameter int ADDR_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 live,
    input  logic [ADDR_BITS-1:0] query_pc,
    input  logic                 wr_en,
    input  logic                 tok_in,
    input  logic                 hit_in,
    output logic                 tok_out,
    output logic                 hit_out
);

    logic [ADDR_BITS-1:0] entry_reg;
    logic                 tok_reg;
    logic                 hit_reg;
    logic                 hit_next;

    // A live entry that equals the query marks the search as a hit.
    assign hit_next = hit_in | (live && (entry_reg == query_pc));

    // Token moves one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // Stored PC and the hit flag travelling with the token.
    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (wr_en)
        begin
            entry_reg <= query_pc;
        end
    end

    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule

// ----- rtl/sgtd_pc_chain.sv -----
// Bounded PC set built as a row of cells with a fill count and append on miss.
module sgtd_pc_chain #(
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = 48,
    parameter int FILL_W    = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ADDR_BITS-1:0]  query_pc,
    output sgtd_pkg::search_res_t res,
    output logic [FILL_W-1:0]     fill
);

    logic [DEPTH:0]    tok;
    logic [DEPTH:0]    hit;
    logic [DEPTH-1:0]  live;
    logic [DEPTH-1:0]  wr_en;
    logic [FILL_W-1:0] fill_reg;
    logic              miss;
    logic              room;

    assign tok[0] = start;
    assign hit[0] = 1'b0;

    // The search ends when the token leaves the last cell.
    assign miss = tok[DEPTH] & ~hit[DEPTH];
    assign room = fill_reg < FILL_W'(DEPTH);

    // Row of cells; entries below the fill count hold stored PCs.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign live[i]  = FILL_W'(i) < fill_reg;
        assign wr_en[i] = miss && (fill_reg == FILL_W'(i));

        sgtd_pc_cell #(
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .live     (live[i]),
            .query_pc (query_pc),
            .wr_en    (wr_en[i]),
            .tok_in   (tok[i]),
            .hit_in   (hit[i]),
            .tok_out  (tok[i+1]),
            .hit_out  (hit[i+1])
        );
    end

    // Fill count grows on every appended PC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (miss && room)
        begin
            fill_reg <= fill_reg + FILL_W'(1);
        end
    end

    assign res.done   = tok[DEPTH];
    assign res.is_new = miss & room;
    assign res.full   = miss & ~room;
    assign fill       = fill_reg;

endmodule

// ----- rtl/spec_gadget_taint_detector.sv -----
// Top level of the speculative-gadget taint detector.
//
// Watches one instruction record per request and tracks misspeculation windows:
// a squashed instruction while idle opens a window, completed memory loads taint
// their destination register, taint spreads through completed instructions, and
// an issued micro-visible instruction reading a tainted register marks the window
// vulnerable; any retired instruction closes the window and clears all taint.
// Each request gives exactly one result request. A request that needs no PC set
// lookup goes straight to the finish state; one that opens a window or reaches
// the found state walks a token through the PC_SET_DEPTH cells of its PC set
// first. One request is processed at a time; a new request is taken while the
// previous result still waits in the output register.
module spec_gadget_taint_detector #(
    parameter int PHYS_REGS    = 256,
    parameter int PC_SET_DEPTH = 64,
    parameter int ADDR_BITS    = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // inst_pc[47:0], issued, completed, retired, mem_load, load_like,
    // micro_visible, load_immediate, dest_reg[8:0], src_a_reg[8:0],
    // src_b_reg[8:0], zero pad
    input  logic [sgtd_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fsm_state[1:0], window_pc[47:0], new_flushed_window,
    // new_vulnerable_window, flushed_windows[31:0], unique_flushed[6:0],
    // vulnerable_hits[31:0], unique_vulnerable[6:0], set_full, zero pad
    output logic [sgtd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int REG_IDX_W = $clog2(PHYS_REGS);
    localparam int FILL_W    = $clog2(PC_SET_DEPTH + 1);

    localparam logic [1:0] C_READY  = 2'd0;
    localparam logic [1:0] C_SEARCH = 2'd1;
    localparam logic [1:0] C_FINISH = 2'd2;

    // Input fields.
    logic [sgtd_pkg::PC_FIELD_W-1:0]  inst_pc;
    logic                             issued;
    logic                             completed;
    logic                             retired;
    logic                             mem_load;
    logic                             load_like;
    logic                             micro_visible;
    logic                             load_immediate;
    logic [sgtd_pkg::REG_FIELD_W-1:0] dest_reg;
    logic [sgtd_pkg::REG_FIELD_W-1:0] src_a_reg;
    logic [sgtd_pkg::REG_FIELD_W-1:0] src_b_reg;

    assign inst_pc        = s_tdata[47:0];
    assign issued         = s_tdata[48];
    assign completed      = s_tdata[49];
    assign retired        = s_tdata[50];
    assign mem_load       = s_tdata[51];
    assign load_like      = s_tdata[52];
    assign micro_visible  = s_tdata[53];
    assign load_immediate = s_tdata[54];
    assign dest_reg       = s_tdata[63:55];
    assign src_a_reg      = s_tdata[72:64];
    assign src_b_reg      = s_tdata[81:73];

    logic [1:0]                    ctl_reg;
    sgtd_pkg::mode_t               mode_reg;
    sgtd_pkg::mode_t               mode_next;
    logic [ADDR_BITS-1:0]          start_pc_reg;
    logic [ADDR_BITS-1:0]          start_pc_next;
    logic [PHYS_REGS-1:0]          taint_reg;
    logic [PHYS_REGS-1:0]          taint_next;
    logic [sgtd_pkg::COUNT_W-1:0]  wcount_reg;
    logic [sgtd_pkg::COUNT_W-1:0]  wcount_next;
    logic [sgtd_pkg::COUNT_W-1:0]  hcount_reg;
    logic [sgtd_pkg::COUNT_W-1:0]  hcount_next;
    logic                          fl_go_reg;
    logic                          fl_go_next;
    logic                          vu_go_reg;
    logic                          vu_go_next;
    logic                          res_new_fl_reg;
    logic                          res_new_vu_reg;
    logic                          res_full_reg;
    logic [sgtd_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tvalid_reg;

    logic                          accept;
    logic                          out_load;
    logic [ADDR_BITS-1:0]          pc;
    logic                          has_dst;
    logic                          has_sa;
    logic                          has_sb;
    logic [REG_IDX_W-1:0]          dst_idx;
    logic [REG_IDX_W-1:0]          sa_idx;
    logic [REG_IDX_W-1:0]          sb_idx;
    logic                          src_tainted;
    logic                          taint_load;

    sgtd_pkg::search_res_t         fl_res;
    sgtd_pkg::search_res_t         vu_res;
    logic [FILL_W-1:0]             fl_fill;
    logic [FILL_W-1:0]             vu_fill;

    assign s_tready = (ctl_reg == C_READY);
    assign accept   = s_tvalid & s_tready;
    assign out_load = (ctl_reg == C_FINISH) && (!m_tvalid_reg || m_tready);

    // Register decode; codes at or above PHYS_REGS mean no register.
    assign pc      = ADDR_BITS'(inst_pc);
    assign has_dst = 32'(dest_reg) < PHYS_REGS;
    assign has_sa  = 32'(src_a_reg) < PHYS_REGS;
    assign has_sb  = 32'(src_b_reg) < PHYS_REGS;
    assign dst_idx = REG_IDX_W'(dest_reg);
    assign sa_idx  = REG_IDX_W'(src_a_reg);
    assign sb_idx  = REG_IDX_W'(src_b_reg);

    assign src_tainted = (has_sa && taint_reg[sa_idx]) || (has_sb && taint_reg[sb_idx]);
    assign taint_load  = mem_load && completed && has_dst;

    // Window state machine and taint propagation for one instruction.
    always_comb
    begin
        mode_next     = mode_reg;
        start_pc_next = start_pc_reg;
        taint_next    = taint_reg;
        wcount_next   = wcount_reg;
        hcount_next   = hcount_reg;
        fl_go_next    = 1'b0;
        vu_go_next    = 1'b0;

        case (mode_reg)
            sgtd_pkg::ST_IDLE:
            begin
                start_pc_next = '1;
                if (!retired)
                begin
                    start_pc_next = pc;
                    wcount_next   = (wcount_reg == '1) ? wcount_reg
                                                       : wcount_reg + 32'd1;
                    fl_go_next    = 1'b1;
                    if (taint_load)
                    begin
                        taint_next[dst_idx] = 1'b1;
                        mode_next           = sgtd_pkg::ST_TAINT;
                    end
                    else
                    begin
                        mode_next = sgtd_pkg::ST_OPEN;
                    end
                end
            end
            sgtd_pkg::ST_OPEN:
            begin
                if (retired)
                begin
                    taint_next = '0;
                    mode_next  = sgtd_pkg::ST_IDLE;
                end
                else if (taint_load)
                begin
                    taint_next[dst_idx] = 1'b1;
                    mode_next           = sgtd_pkg::ST_TAINT;
                end
            end
            sgtd_pkg::ST_TAINT:
            begin
                if (retired)
                begin
                    taint_next = '0;
                    mode_next  = sgtd_pkg::ST_IDLE;
                end
                else
                begin
                    if (issued && micro_visible && src_tainted)
                    begin
                        mode_next = sgtd_pkg::ST_FOUND;
                    end
                    if (completed && has_dst && (mem_load || src_tainted))
                    begin
                        taint_next[dst_idx] = 1'b1;
                    end
                    else if (completed && has_dst &&
                             ((load_like && !src_tainted) || load_immediate))
                    begin
                        taint_next[dst_idx] = 1'b0;
                    end
                end
            end
            sgtd_pkg::ST_FOUND:
            begin
                mode_next = sgtd_pkg::ST_FOUND;
            end
            default:
            begin
                mode_next = sgtd_pkg::ST_IDLE;
            end
        endcase

        // Transmitter found: count the hit, record the window, close on retire.
        if (mode_next == sgtd_pkg::ST_FOUND)
        begin
            hcount_next = (hcount_reg == '1) ? hcount_reg : hcount_reg + 32'd1;
            vu_go_next  = 1'b1;
            if (retired)
            begin
                taint_next = '0;
                mode_next  = sgtd_pkg::ST_IDLE;
            end
        end
    end

    // Architectural state, updated when an instruction request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= sgtd_pkg::ST_IDLE;
            start_pc_reg <= '1;
            taint_reg    <= '0;
            wcount_reg   <= '0;
            hcount_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            start_pc_reg <= start_pc_next;
            taint_reg    <= taint_next;
            wcount_reg   <= wcount_next;
            hcount_reg   <= hcount_next;
        end
    end

    // Sequencer: take a request, run a set lookup if needed, hand off the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= C_READY;
        end
        else
        begin
            case (ctl_reg)
                C_READY:
                begin
                    if (accept)
                    begin
                        ctl_reg <= (fl_go_next || vu_go_next) ? C_SEARCH : C_FINISH;
                    end
                end
                C_SEARCH:
                begin
                    if (fl_res.done || vu_res.done)
                    begin
                        ctl_reg <= C_FINISH;
                    end
                end
                C_FINISH:
                begin
                    if (out_load)
                    begin
                        ctl_reg <= C_READY;
                    end
                end
                default:
                begin
                    ctl_reg <= C_READY;
                end
            endcase
        end
    end

    // Lookup start pulses, raised for one cycle after a request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_go_reg <= 1'b0;
            vu_go_reg <= 1'b0;
        end
        else
        begin
            fl_go_reg <= accept & fl_go_next;
            vu_go_reg <= accept & vu_go_next;
        end
    end

    // Result valid: set when a result is loaded, cleared when it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result flags and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_new_fl_reg <= 1'b0;
            res_new_vu_reg <= 1'b0;
            res_full_reg   <= 1'b0;
        end
        else if (ctl_reg == C_SEARCH)
        begin
            if (fl_res.done)
            begin
                res_new_fl_reg <= fl_res.is_new;
                res_full_reg   <= fl_res.full;
            end
            else if (vu_res.done)
            begin
                res_new_vu_reg <= vu_res.is_new;
                res_full_reg   <= vu_res.full;
            end
        end
        if (out_load)
        begin
            m_tdata_reg <= {
                {sgtd_pkg::OUT_PAD_W{1'b0}},
                res_full_reg,
                sgtd_pkg::UNIQUE_W'(vu_fill),
                hcount_reg,
                sgtd_pkg::UNIQUE_W'(fl_fill),
                wcount_reg,
                res_new_vu_reg,
                res_new_fl_reg,
                sgtd_pkg::PC_FIELD_W'(start_pc_reg),
                mode_reg
            };
        end
    end

    // Flushed-window PC set.
    sgtd_pc_chain #(
        .DEPTH     (PC_SET_DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .FILL_W    (FILL_W)
    ) u_flushed_set (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fl_go_reg),
        .query_pc (start_pc_reg),
        .res      (fl_res),
        .fill     (fl_fill)
    );

    // Vulnerable-window PC set.
    sgtd_pc_chain #(
        .DEPTH     (PC_SET_DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .FILL_W    (FILL_W)
    ) u_vuln_set (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (vu_go_reg),
        .query_pc (start_pc_reg),
        .res      (vu_res),
        .fill     (vu_fill)
    );

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- bench/spec_gadget_taint_detector_test.sv -----
// Self-checking stream testbench for the speculative-gadget taint detector.
`timescale 1ns / 1ps

module spec_gadget_taint_detector_test;

    // Package widths and mode codes used throughout the bench.
    localparam int REG_FIELD_W = sgtd_pkg::REG_FIELD_W;
    localparam int PC_FIELD_W  = sgtd_pkg::PC_FIELD_W;
    localparam int UNIQUE_W    = sgtd_pkg::UNIQUE_W;
    localparam int COUNT_W     = sgtd_pkg::COUNT_W;
    localparam int IN_TDATA_W  = sgtd_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = sgtd_pkg::OUT_TDATA_W;
    localparam int IN_PAD_W    = sgtd_pkg::IN_PAD_W;
    localparam int OUT_PAD_W   = sgtd_pkg::OUT_PAD_W;

    typedef sgtd_pkg::mode_t mode_t;

    localparam mode_t ST_IDLE  = sgtd_pkg::ST_IDLE;
    localparam mode_t ST_OPEN  = sgtd_pkg::ST_OPEN;
    localparam mode_t ST_TAINT = sgtd_pkg::ST_TAINT;
    localparam mode_t ST_FOUND = sgtd_pkg::ST_FOUND;

    localparam int         PHYS_REGS    = 256;
    localparam int         SET_DEPTH    = 64;
    localparam logic [8:0] NO_REG       = 9'd256;
    localparam int         SET_FLUSHED  = 0;
    localparam int         SET_VULN     = 1;
    localparam int         IDLE_PCT     = 24;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 2 * SET_DEPTH + 20;
    localparam int         ITEM_GOAL    = 1700;
    localparam longint     TIMEOUT_NS   = 10_000_000;

    // One instruction record, packed from the top bit down as it sits in s_tdata.
    typedef struct packed {
        logic [REG_FIELD_W-1:0] src_b_reg;
        logic [REG_FIELD_W-1:0] src_a_reg;
        logic [REG_FIELD_W-1:0] dest_reg;
        logic                   load_immediate;
        logic                   micro_visible;
        logic                   load_like;
        logic                   mem_load;
        logic                   retired;
        logic                   completed;
        logic                   issued;
        logic [PC_FIELD_W-1:0]  inst_pc;
    } instr_t;

    // One detector verdict, packed from the top bit down as it sits in m_tdata.
    typedef struct packed {
        logic                   set_full;
        logic [UNIQUE_W-1:0]    unique_vulnerable;
        logic [COUNT_W-1:0]     vulnerable_hits;
        logic [UNIQUE_W-1:0]    unique_flushed;
        logic [COUNT_W-1:0]     flushed_windows;
        logic                   new_vulnerable_window;
        logic                   new_flushed_window;
        logic [PC_FIELD_W-1:0]  window_pc;
        mode_t                  fsm_state;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    // Shadow state of the detector.
    mode_t                  cur_mode;
    logic [PC_FIELD_W-1:0]  win_pc;
    bit                     taint_map [PHYS_REGS];
    logic [PC_FIELD_W-1:0]  pc_sets [2][SET_DEPTH];
    int                     set_fill [2];
    logic [COUNT_W-1:0]     window_total;
    logic [COUNT_W-1:0]     hit_total;

    verdict_t               verdict_q [$];
    logic [PC_FIELD_W-1:0]  recent_pcs [$];

    int                     send_idle_pct = IDLE_PCT;
    int                     recv_idle_pct = IDLE_PCT;
    int                     hold_serial = 0;
    int                     mismatches = 0;
    int                     items_sent = 0;
    int                     results_checked = 0;
    int                     found_seen = 0;
    int                     full_seen = 0;

    spec_gadget_taint_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic logic [COUNT_W-1:0] sat_next(input logic [COUNT_W-1:0] c);
        return (c == '1) ? c : c + COUNT_W'(1);
    endfunction

    function automatic bit reg_hot(input logic [REG_FIELD_W-1:0] r);
        return r < PHYS_REGS && taint_map[r[7:0]];
    endfunction

    function automatic void clear_taint();
        foreach (taint_map[i])
            taint_map[i] = 1'b0;
    endfunction

    // Look the PC up in one set; store it if it is new and there is room.
    function automatic logic store_pc(input int which, input logic [PC_FIELD_W-1:0] pc,
                                      inout logic full);
        for (int i = 0; i < set_fill[which]; i++)
            if (pc_sets[which][i] == pc)
                return 1'b0;
        if (set_fill[which] >= SET_DEPTH)
        begin
            full = 1'b1;
            return 1'b0;
        end
        pc_sets[which][set_fill[which]] = pc;
        set_fill[which]++;
        return 1'b1;
    endfunction

    function automatic void reset_shadow();
        cur_mode              = ST_IDLE;
        win_pc                = '1;
        set_fill[SET_FLUSHED] = 0;
        set_fill[SET_VULN]    = 0;
        window_total          = '0;
        hit_total             = '0;
        clear_taint();
    endfunction

    // Advance the shadow state by one instruction and return the verdict it gives.
    function automatic verdict_t predict_verdict(input instr_t it);
        verdict_t v;
        logic     has_dst;
        logic     src_hot;
        logic     full;
        logic     new_fl;
        logic     new_vu;
        has_dst = it.dest_reg < PHYS_REGS;
        src_hot = reg_hot(it.src_a_reg) || reg_hot(it.src_b_reg);
        full    = 1'b0;
        new_fl  = 1'b0;
        new_vu  = 1'b0;

        if (cur_mode == ST_IDLE)
        begin
            // A squash while idle opens a window at this PC.
            win_pc = '1;
            if (!it.retired)
            begin
                win_pc       = it.inst_pc;
                window_total = sat_next(window_total);
                new_fl       = store_pc(SET_FLUSHED, it.inst_pc, full);
                if (it.mem_load && it.completed && has_dst)
                begin
                    taint_map[it.dest_reg[7:0]] = 1'b1;
                    cur_mode = ST_TAINT;
                end
                else
                begin
                    cur_mode = ST_OPEN;
                end
            end
        end
        else if (cur_mode == ST_OPEN)
        begin
            if (it.retired)
            begin
                clear_taint();
                cur_mode = ST_IDLE;
            end
            else if (it.mem_load && it.completed && has_dst)
            begin
                taint_map[it.dest_reg[7:0]] = 1'b1;
                cur_mode = ST_TAINT;
            end
        end
        else if (cur_mode == ST_TAINT)
        begin
            if (it.retired)
            begin
                clear_taint();
                cur_mode = ST_IDLE;
            end
            else
            begin
                if (it.issued && it.micro_visible && src_hot)
                    cur_mode = ST_FOUND;
                // Taint spreads to the destination, or an untainted or immediate load clears it.
                if (it.completed && has_dst && (it.mem_load || src_hot))
                    taint_map[it.dest_reg[7:0]] = 1'b1;
                else if (it.completed && has_dst &&
                         ((it.load_like && !src_hot) || it.load_immediate) &&
                         taint_map[it.dest_reg[7:0]])
                    taint_map[it.dest_reg[7:0]] = 1'b0;
            end
        end

        // Every item seen with a transmitter found counts a hit.
        if (cur_mode == ST_FOUND)
        begin
            hit_total = sat_next(hit_total);
            new_vu    = store_pc(SET_VULN, win_pc, full);
            if (it.retired)
            begin
                clear_taint();
                cur_mode = ST_IDLE;
            end
        end

        v.fsm_state             = cur_mode;
        v.window_pc             = win_pc;
        v.new_flushed_window    = new_fl;
        v.new_vulnerable_window = new_vu;
        v.flushed_windows       = window_total;
        v.unique_flushed        = UNIQUE_W'(set_fill[SET_FLUSHED]);
        v.vulnerable_hits       = hit_total;
        v.unique_vulnerable     = UNIQUE_W'(set_fill[SET_VULN]);
        v.set_full              = full;
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h (result %0d)",
                                      name, got, want, results_checked));
    endtask

    // Compare one returned verdict with the oldest expected one.
    task automatic check_verdict(input verdict_t got);
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            report_mismatch("result arrived with none expected");
            return;
        end
        want = verdict_q.pop_front();
        compare_field("fsm_state", 64'(got.fsm_state), 64'(want.fsm_state));
        compare_field("window_pc", 64'(got.window_pc), 64'(want.window_pc));
        compare_field("new_flushed_window", 64'(got.new_flushed_window),
                      64'(want.new_flushed_window));
        compare_field("new_vulnerable_window", 64'(got.new_vulnerable_window),
                      64'(want.new_vulnerable_window));
        compare_field("flushed_windows", 64'(got.flushed_windows),
                      64'(want.flushed_windows));
        compare_field("unique_flushed", 64'(got.unique_flushed),
                      64'(want.unique_flushed));
        compare_field("vulnerable_hits", 64'(got.vulnerable_hits),
                      64'(want.vulnerable_hits));
        compare_field("unique_vulnerable", 64'(got.unique_vulnerable),
                      64'(want.unique_vulnerable));
        compare_field("set_full", 64'(got.set_full), 64'(want.set_full));
        results_checked++;
        if (want.fsm_state == ST_FOUND)
            found_seen++;
        if (want.set_full)
            full_seen++;
    endtask

    // Result side: check each accepted result, then choose the next tready.
    initial
    begin : result_side
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_verdict(m_tdata[OUT_TDATA_W-OUT_PAD_W-1:0]);
            if (hold_serial != hold_seen)
            begin
                hold_seen = hold_serial;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request, wait for it to be taken, and record its expected verdict.
    task automatic send_instr(input instr_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD_W{1'b0}}, it};
        do
            @(posedge clk);
        while (!s_tready);
        verdict_q.insert(verdict_q.size(), predict_verdict(it));
        items_sent++;
    endtask

    // Drop tvalid and wait until every expected verdict has come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PC_FIELD_W-1:0] any_pc();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PC_FIELD_W-1:0];
    endfunction

    // Mostly a handful of low registers so that taint meets itself often.
    function automatic logic [REG_FIELD_W-1:0] pick_reg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return NO_REG;
        if (r < 70)
            return REG_FIELD_W'($urandom_range(0, 7));
        return REG_FIELD_W'($urandom_range(0, PHYS_REGS - 1));
    endfunction

    function automatic instr_t quiet_instr(input logic [PC_FIELD_W-1:0] pc);
        instr_t it;
        it           = '0;
        it.inst_pc   = pc;
        it.dest_reg  = NO_REG;
        it.src_a_reg = NO_REG;
        it.src_b_reg = NO_REG;
        return it;
    endfunction

    function automatic instr_t wild_instr();
        instr_t it;
        it.inst_pc        = any_pc();
        it.issued         = 1'($urandom_range(0, 1));
        it.completed      = 1'($urandom_range(0, 1));
        it.retired        = 1'($urandom_range(0, 1));
        it.mem_load       = 1'($urandom_range(0, 1));
        it.load_like      = 1'($urandom_range(0, 1));
        it.micro_visible  = 1'($urandom_range(0, 1));
        it.load_immediate = 1'($urandom_range(0, 1));
        it.dest_reg       = REG_FIELD_W'($urandom_range(0, PHYS_REGS));
        it.src_a_reg      = REG_FIELD_W'($urandom_range(0, PHYS_REGS));
        it.src_b_reg      = REG_FIELD_W'($urandom_range(0, PHYS_REGS));
        return it;
    endfunction

    function automatic instr_t shaped_instr();
        instr_t it;
        it           = wild_instr();
        it.dest_reg  = pick_reg();
        it.src_a_reg = pick_reg();
        it.src_b_reg = pick_reg();
        return it;
    endfunction

    // Fresh PCs mostly, some reused so that repeated windows are seen too.
    function automatic logic [PC_FIELD_W-1:0] choose_window_pc();
        logic [PC_FIELD_W-1:0] pc;
        if (recent_pcs.size() > 0 && $urandom_range(0, 99) < 30)
        begin
            pc = recent_pcs[$urandom_range(0, recent_pcs.size() - 1)];
        end
        else
        begin
            pc = any_pc();
            recent_pcs.insert(recent_pcs.size(), pc);
            if (recent_pcs.size() > 16)
                void'(recent_pcs.pop_front());
        end
        return pc;
    endfunction

    // Send the shaped request, or now and then a fully random one instead.
    task automatic send_or_noise(input instr_t it);
        if ($urandom_range(0, 99) < 8)
            send_instr(wild_instr());
        else
            send_instr(it);
    endtask

    // A squash window with a tainting load, some spreading and a transmitter.
    task automatic run_gadget();
        instr_t                 it;
        logic [REG_FIELD_W-1:0] hot;
        it = shaped_instr();
        it.inst_pc = choose_window_pc();
        it.retired = 1'b0;
        send_or_noise(it);
        repeat ($urandom_range(0, 2))
        begin
            it = shaped_instr();
            it.retired = 1'b0;
            send_or_noise(it);
        end

        // Tainting load, then a chain that carries the taint on.
        hot = pick_reg();
        it = shaped_instr();
        it.retired   = 1'b0;
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        it.dest_reg  = hot;
        send_or_noise(it);
        repeat ($urandom_range(0, 2))
        begin
            it = shaped_instr();
            it.retired   = 1'b0;
            it.completed = 1'b1;
            it.src_a_reg = hot;
            hot = pick_reg();
            it.dest_reg  = hot;
            send_or_noise(it);
        end

        // Transmitter reading the last tainted register, then the closing commit.
        it = shaped_instr();
        it.retired       = 1'b0;
        it.issued        = 1'b1;
        it.micro_visible = 1'b1;
        it.src_b_reg     = hot;
        send_or_noise(it);
        repeat ($urandom_range(0, 2))
        begin
            it = shaped_instr();
            it.retired = 1'b0;
            send_or_noise(it);
        end
        it = shaped_instr();
        it.retired = 1'b1;
        send_or_noise(it);
    endtask

    // Extremes of the fields and every transition of the window machine.
    task automatic test_directed_corners();
        instr_t it;
        // Commits while idle keep the window closed.
        it = quiet_instr('0);
        it.retired = 1'b1;
        send_instr(it);
        it = '1;
        it.dest_reg  = 9'd255;
        it.src_a_reg = 9'd255;
        it.src_b_reg = 9'd255;
        send_instr(it);

        // Open at PC zero; loads with no destination leave the window open.
        it = quiet_instr('0);
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        send_instr(it);
        send_instr(it);

        // Taint register 0, spread it to 255, then untaint with a load-immediate.
        it.dest_reg = 9'd0;
        send_instr(it);
        it = quiet_instr('0);
        it.completed = 1'b1;
        it.src_a_reg = 9'd0;
        it.dest_reg  = 9'd255;
        send_instr(it);
        it = quiet_instr('0);
        it.issued        = 1'b1;
        it.micro_visible = 1'b1;
        it.src_b_reg     = 9'd5;
        send_instr(it);
        it = quiet_instr('0);
        it.completed      = 1'b1;
        it.load_immediate = 1'b1;
        it.dest_reg       = 9'd255;
        send_instr(it);

        // A load reading tainted data keeps its destination tainted; a clean one clears it.
        it = quiet_instr('0);
        it.completed = 1'b1;
        it.load_like = 1'b1;
        it.src_a_reg = 9'd0;
        it.dest_reg  = 9'd0;
        send_instr(it);
        it.src_a_reg = NO_REG;
        send_instr(it);

        // Retaint 255 and hit it with a transmitter, then stay and commit.
        it = quiet_instr('0);
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        it.dest_reg  = 9'd255;
        send_instr(it);
        it = quiet_instr('0);
        it.issued        = 1'b1;
        it.micro_visible = 1'b1;
        it.src_b_reg     = 9'd255;
        send_instr(it);
        send_instr(quiet_instr('1));
        it = quiet_instr('1);
        it.retired = 1'b1;
        send_instr(it);

        // A squashed load while idle goes straight to tainted; PC zero is not new.
        it = quiet_instr('0);
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        it.dest_reg  = 9'd7;
        send_instr(it);
        it = quiet_instr('0);
        it.retired = 1'b1;
        send_instr(it);

        // All flags set at the top PC with no registers, closed by a commit.
        it = '1;
        it.retired   = 1'b0;
        it.dest_reg  = NO_REG;
        it.src_a_reg = NO_REG;
        it.src_b_reg = NO_REG;
        send_instr(it);
        it.retired = 1'b1;
        send_instr(it);

        // A committing transmitter closes the window before it can count.
        it = quiet_instr(48'h0000_1234_5678);
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        it.dest_reg  = 9'd3;
        send_instr(it);
        it = quiet_instr(48'h0000_1234_5678);
        it.issued        = 1'b1;
        it.micro_visible = 1'b1;
        it.src_a_reg     = 9'd3;
        it.retired       = 1'b1;
        send_instr(it);

        // Transmitter that also spreads taint, then a committing item in found state.
        it = quiet_instr(48'h8000_0000_0001);
        it.completed = 1'b1;
        it.mem_load  = 1'b1;
        it.dest_reg  = 9'd1;
        send_instr(it);
        it = quiet_instr(48'h8000_0000_0001);
        it.issued        = 1'b1;
        it.micro_visible = 1'b1;
        it.completed     = 1'b1;
        it.src_a_reg     = 9'd1;
        it.dest_reg      = 9'd2;
        send_instr(it);
        it = '1;
        send_instr(it);
        wait_drain();
    endtask

    // Random gadget windows mixed with noise, up to a total number of requests.
    task automatic test_random_windows(input int goal);
        while (items_sent < goal)
            run_gadget();
        wait_drain();
    endtask

    // Back-to-back traffic on both sides.
    task automatic test_no_idle_stream();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (25)
            run_gadget();
        wait_drain();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        send_idle_pct = 0;
        hold_serial++;
        repeat (4)
            run_gadget();
        wait_drain();
        send_idle_pct = IDLE_PCT;
    endtask

    // Short vulnerable windows at fresh PCs until both PC sets overflow.
    task automatic test_fill_pc_sets();
        instr_t it;
        int     extra;
        extra = 0;
        while (extra < 8)
        begin
            if (set_fill[SET_VULN] >= SET_DEPTH)
                extra++;
            it = shaped_instr();
            it.inst_pc   = any_pc();
            it.retired   = 1'b0;
            it.completed = 1'b1;
            it.mem_load  = 1'b1;
            it.dest_reg  = 9'd5;
            send_instr(it);
            it = shaped_instr();
            it.retired       = 1'b0;
            it.issued        = 1'b1;
            it.micro_visible = 1'b1;
            it.src_a_reg     = 9'd5;
            send_instr(it);
            it = shaped_instr();
            it.retired = 1'b1;
            send_instr(it);
        end
        wait_drain();
    endtask

    // Test sequence.
    initial
    begin
        reset_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_windows(500);
        test_no_idle_stream();
        test_output_stall();
        test_fill_pc_sets();
        test_random_windows(ITEM_GOAL);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d instruction records (directed corners, gadget windows, noise,",
                 items_sent);
        $display("stalls, set overflow): %0d verdicts checked, %0d found, %0d with a full set.",
                 results_checked, found_seen, full_seen);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d verdicts outstanding.", verdict_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
